// File: sv/slxfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_pkg
// Shared types, codes and constants of the sync/length/XOR frame parser.
// ----------------------------------------------------------------------------
package slxfp_pkg;

  localparam logic [7:0] SYNC_RESET    = 8'hAA;
  localparam logic [9:0] MAX_LEN_RESET = 10'd512;

  localparam logic [7:0] MT_HEARTBEAT = 8'h01;
  localparam logic [7:0] MT_FWD_A     = 8'h02;
  localparam logic [7:0] MT_FWD_B     = 8'h03;
  localparam logic [7:0] MT_FWD_C     = 8'h04;
  localparam logic [7:0] MT_STATS     = 8'h05;

  typedef enum logic [0:0] {
    REG_SYNC_VALUE = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_SYNC    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_ADDR    = 4'd2,
    PH_INDEX   = 4'd3,
    PH_PROTO   = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_LEN_HI  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CHECK   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    EV_GOOD     = 2'd0,
    EV_CHECKSUM = 2'd1,
    EV_LENGTH   = 2'd2,
    EV_READ     = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    CL_HEARTBEAT = 2'd0,
    CL_FORWARDED = 2'd1,
    CL_STATS     = 2'd2,
    CL_UNKNOWN   = 2'd3
  } class_e;

  typedef struct packed {
    event_e     event_res;
    class_e     frame_class;
    logic [7:0] message_type;
    logic [7:0] device_address;
    logic [7:0] interface_index;
    logic [7:0] interface_protocol;
    logic [9:0] payload_length;
    logic [7:0] data_byte;
  } res_t;

  function automatic class_e class_of(logic [7:0] t);
    class_e c;
    case (t)
      MT_HEARTBEAT:                   c = CL_HEARTBEAT;
      MT_FWD_A, MT_FWD_B, MT_FWD_C:   c = CL_FORWARDED;
      MT_STATS:                       c = CL_STATS;
      default:                        c = CL_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

// File: sv/slxfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_parser
// Byte-serial frame state machine: header capture, length check, payload
// write port, running XOR and event generation.
// ----------------------------------------------------------------------------
module slxfp_parser #(
  parameter int BUFFER_DEPTH = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rx_valid_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [7:0]                      sync_value_i,
  input  logic [9:0]                      max_length_i,
  output logic                            res_valid_o,
  output slxfp_pkg::res_t                 res_o,
  output logic                            wr_en_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr_o,
  output logic [7:0]                      wr_data_o,
  output logic [9:0]                      last_good_o
);
  import slxfp_pkg::*;

  localparam int          AW      = $clog2(BUFFER_DEPTH);
  localparam int          EW      = AW + 10;
  localparam logic [15:0] DEPTH16 = 16'(BUFFER_DEPTH);

  phase_e     phase_q, phase_d;
  logic [7:0] type_q, type_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] index_q, index_d;
  logic [7:0] proto_q, proto_d;
  logic [7:0] len_lo_q, len_lo_d;
  logic [9:0] declared_q, declared_d;
  logic [9:0] count_q, count_d;
  logic [7:0] xor_q, xor_d;
  logic [9:0] last_good_q, last_good_d;

  logic [15:0]   len_full;
  logic [9:0]    count_inc;
  logic [EW-1:0] wext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC;
      type_q      <= '0;
      addr_q      <= '0;
      index_q     <= '0;
      proto_q     <= '0;
      len_lo_q    <= '0;
      declared_q  <= '0;
      count_q     <= '0;
      xor_q       <= '0;
      last_good_q <= '0;
    end else begin
      phase_q     <= phase_d;
      type_q      <= type_d;
      addr_q      <= addr_d;
      index_q     <= index_d;
      proto_q     <= proto_d;
      len_lo_q    <= len_lo_d;
      declared_q  <= declared_d;
      count_q     <= count_d;
      xor_q       <= xor_d;
      last_good_q <= last_good_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    addr_d      = addr_q;
    index_d     = index_q;
    proto_d     = proto_q;
    len_lo_d    = len_lo_q;
    declared_d  = declared_q;
    count_d     = count_q;
    xor_d       = xor_q;
    last_good_d = last_good_q;

    len_full  = {rx_byte_i, len_lo_q};
    count_inc = count_q + 10'd1;
    wext      = EW'(count_q);
    wr_addr_o = wext[AW-1:0];
    wr_data_o = rx_byte_i;
    wr_en_o   = 1'b0;

    res_valid_o                 = 1'b0;
    res_o.event_res             = EV_GOOD;
    res_o.frame_class           = CL_HEARTBEAT;
    res_o.message_type          = type_q;
    res_o.device_address        = addr_q;
    res_o.interface_index       = index_q;
    res_o.interface_protocol    = proto_q;
    res_o.payload_length        = '0;
    res_o.data_byte             = '0;

    if (rx_valid_i) begin
      unique case (phase_q)
        PH_SYNC: begin
          if (rx_byte_i == sync_value_i) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          type_d  = rx_byte_i;
          xor_d   = rx_byte_i;
          phase_d = PH_ADDR;
        end
        PH_ADDR: begin
          addr_d  = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_INDEX;
        end
        PH_INDEX: begin
          index_d = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_PROTO;
        end
        PH_PROTO: begin
          proto_d = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_d = rx_byte_i;
          xor_d    = xor_q ^ rx_byte_i;
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          xor_d = xor_q ^ rx_byte_i;
          if ((len_full > {6'b0, max_length_i}) || (len_full > DEPTH16)) begin
            phase_d         = PH_SYNC;
            res_valid_o     = 1'b1;
            res_o.event_res = EV_LENGTH;
          end else begin
            declared_d = len_full[9:0];
            count_d    = '0;
            phase_d    = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          wr_en_o = 1'b1;
          count_d = count_inc;
          xor_d   = xor_q ^ rx_byte_i;
          if (count_inc >= declared_q) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          phase_d     = PH_SYNC;
          res_valid_o = 1'b1;
          if (rx_byte_i == xor_q) begin
            last_good_d          = count_q;
            res_o.event_res      = EV_GOOD;
            res_o.frame_class    = class_of(type_q);
            res_o.payload_length = count_q;
          end else begin
            res_o.event_res = EV_CHECKSUM;
          end
        end
        default: begin
          phase_d = PH_SYNC;
        end
      endcase
    end
  end

  assign last_good_o = last_good_q;

endmodule

// File: sv/slxfp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slxfp_out_buf
// Two-entry result buffer driving the master stream; decouples the result
// stage from downstream back-pressure.
// ----------------------------------------------------------------------------
module slxfp_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slxfp_pkg::res_t push_res_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output slxfp_pkg::res_t res_o
);
  import slxfp_pkg::*;

  res_t       ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign room_o  = (count_q != 2'd2) || pop;
  assign res_o   = ent_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + 2'd1;
    else if (!push_i && pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_ptr_q] <= push_res_i;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push into full result buffer");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) && !ready_i |=> (count_q == 2'd2) && $stable(res_o))
    else $error("stalled full buffer changed");

endmodule

// File: sv/sync_length_xor_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Deframes a sync/header/length/payload/XOR byte stream and serves reads of
// the stored payload.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle while the slave side is not
// stalled, receive and read alike. A line byte updates the frame state
// machine and, in the payload phase, writes one buffer entry in the cycle it
// is taken; a read looks up the payload buffer through its single registered
// read port. A result passes through the result stage (which also covers the
// buffer read latency) and then the two-entry output buffer before it appears
// on the master stream. The slave side stalls only when three results wait
// downstream (one in the result stage, two in the output buffer) and the
// master side is not ready. The payload buffer holds BUFFER_DEPTH bytes and
// needs no clearing after reset; reads at or beyond the last good frame
// length return zero.
module sync_length_xor_frame_parser #(
  parameter int BUFFER_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // rx_byte[7:0], read_index[16:8], zero pad
  input  logic        s_axis_tuser,  // action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // frame_class[1:0], message_type[9:2],
                                     // device_address[17:10],
                                     // interface_index[25:18],
                                     // interface_protocol[33:26],
                                     // payload_length[43:34],
                                     // data_byte[51:44], zero pad
  output logic [1:0]  m_axis_tuser   // event_res
);
  import slxfp_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int RW = AW + 9;

  logic [7:0] sync_value_q;
  logic [9:0] max_length_q;
  logic       cfg_wr;

  logic          s_acc;
  logic          rd_acc;
  logic          rx_acc;
  logic [7:0]    rx_byte;
  logic [8:0]    read_index;
  logic [RW-1:0] rext;
  logic          rd_hit;

  logic          par_valid;
  res_t          par_res;
  logic          par_wr_en;
  logic [AW-1:0] par_wr_addr;
  logic [7:0]    par_wr_data;
  logic [9:0]    last_good;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] mem_q;

  logic p_valid_q;
  res_t p_res_q;
  logic p_hit_q;
  logic p_adv;
  res_t push_res;
  res_t read_res;

  logic buf_room;
  res_t out_res;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q <= SYNC_RESET;
      max_length_q <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_SYNC_VALUE: sync_value_q <= pwdata[7:0];
        REG_MAX_LENGTH: max_length_q <= pwdata[9:0];
        default:        sync_value_q <= sync_value_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_SYNC_VALUE: prdata = {24'b0, sync_value_q};
      REG_MAX_LENGTH: prdata = {22'b0, max_length_q};
      default:        prdata = '0;
    endcase
  end

  // input side
  assign rx_byte    = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[16:8];
  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign rd_acc     = s_acc && s_axis_tuser;
  assign rx_acc     = s_acc && !s_axis_tuser;
  assign rext       = RW'(read_index);
  assign rd_hit     = ({1'b0, read_index} < last_good);

  slxfp_parser #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_acc),
    .rx_byte_i    (rx_byte),
    .sync_value_i (sync_value_q),
    .max_length_i (max_length_q),
    .res_valid_o  (par_valid),
    .res_o        (par_res),
    .wr_en_o      (par_wr_en),
    .wr_addr_o    (par_wr_addr),
    .wr_data_o    (par_wr_data),
    .last_good_o  (last_good)
  );

  // payload buffer
  always_ff @(posedge clk_i) begin
    if (par_wr_en) mem[par_wr_addr] <= par_wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_acc) mem_q <= mem[rext[AW-1:0]];
  end

  // result stage
  assign p_adv         = p_valid_q && buf_room;
  assign s_axis_tready = !p_valid_q || p_adv;

  always_comb begin
    read_res           = '0;
    read_res.event_res = EV_READ;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (s_acc && (s_axis_tuser || par_valid)) begin
      p_valid_q <= 1'b1;
    end else if (p_adv) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p_hit_q <= s_axis_tuser && rd_hit;
      p_res_q <= s_axis_tuser ? read_res : par_res;
    end
  end

  always_comb begin
    push_res           = p_res_q;
    push_res.data_byte = p_hit_q ? mem_q : 8'd0;
  end

  slxfp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (p_adv),
    .push_res_i (push_res),
    .room_o     (buf_room),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (out_res)
  );

  assign m_axis_tuser = out_res.event_res;
  assign m_axis_tdata = {4'b0,
                         out_res.data_byte,
                         out_res.payload_length,
                         out_res.interface_protocol,
                         out_res.interface_index,
                         out_res.device_address,
                         out_res.message_type,
                         out_res.frame_class};

  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> p_valid_q && (p_res_q.event_res == EV_READ))
    else $error("read transaction produced no read result");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !p_adv |=> p_valid_q && $stable(p_res_q) && $stable(p_hit_q) &&
                            (!p_hit_q || $stable(mem_q)))
    else $error("result stage lost a stalled result");

  a_hit_is_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && p_hit_q |-> p_res_q.event_res == EV_READ)
    else $error("buffer data attached to a frame event");

endmodule
